### hw/rtl/skf_pkg.sv
// Shared constants, control word type and microcode table of the scalar Kalman filter.
package skf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int VAR_W     = 31;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int PC_W      = 5;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(64'd1 << FRAC_BITS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR    = 3'd5;

    // Micro-operations.
    localparam logic [3:0] OP_MUL    = 4'd0;  // product register <= a * b
    localparam logic [3:0] OP_MRES   = 4'd1;  // dst <= scaled, saturated product
    localparam logic [3:0] OP_MRESC  = 4'd2;  // same, negative clamped to zero
    localparam logic [3:0] OP_ADD    = 4'd3;
    localparam logic [3:0] OP_SUB    = 4'd4;
    localparam logic [3:0] OP_BRNP   = 4'd5;  // jump when denominator is not positive
    localparam logic [3:0] OP_DSTART = 4'd6;
    localparam logic [3:0] OP_DWAIT  = 4'd7;
    localparam logic [3:0] OP_JMP    = 4'd8;
    localparam logic [3:0] OP_CLRK   = 4'd9;  // gain <= 0, flag error
    localparam logic [3:0] OP_DONE   = 4'd10;

    // Operand sources.
    localparam logic [3:0] SRC_A    = 4'd0;
    localparam logic [3:0] SRC_H    = 4'd1;
    localparam logic [3:0] SRC_Q    = 4'd2;
    localparam logic [3:0] SRC_R    = 4'd3;
    localparam logic [3:0] SRC_X    = 4'd4;
    localparam logic [3:0] SRC_P    = 4'd5;
    localparam logic [3:0] SRC_Z    = 4'd6;
    localparam logic [3:0] SRC_ONE  = 4'd7;
    localparam logic [3:0] SRC_XP   = 4'd8;
    localparam logic [3:0] SRC_PP   = 4'd9;
    localparam logic [3:0] SRC_T    = 4'd10;
    localparam logic [3:0] SRC_K    = 4'd11;
    localparam logic [3:0] SRC_RES  = 4'd12;
    localparam logic [3:0] SRC_DEN  = 4'd13;

    // Destinations.
    localparam logic [2:0] DST_X   = 3'd0;
    localparam logic [2:0] DST_P   = 3'd1;
    localparam logic [2:0] DST_XP  = 3'd2;
    localparam logic [2:0] DST_PP  = 3'd3;
    localparam logic [2:0] DST_T   = 3'd4;
    localparam logic [2:0] DST_K   = 3'd5;
    localparam logic [2:0] DST_RES = 3'd6;
    localparam logic [2:0] DST_DEN = 3'd7;

    // Jump targets in the program.
    localparam logic [PC_W-1:0] STEP_NO_GAIN = 5'd18;
    localparam logic [PC_W-1:0] STEP_RESID   = 5'd19;

    typedef struct packed {
        logic [3:0]      op;
        logic [3:0]      src_a;
        logic [3:0]      src_b;
        logic [2:0]      dst;
        logic [PC_W-1:0] target;
    } t_uword;

    function automatic t_uword uw(input logic [3:0] op, input logic [3:0] a,
                                  input logic [3:0] b, input logic [2:0] d,
                                  input logic [PC_W-1:0] t);
        t_uword w;
        w.op = op;
        w.src_a = a;
        w.src_b = b;
        w.dst = d;
        w.target = t;
        return w;
    endfunction

    // The filter program: predict, gain, update.
    function automatic t_uword skf_urom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            5'd0:  w = uw(OP_MUL,    SRC_A,   SRC_X,  DST_T,   '0);
            5'd1:  w = uw(OP_MRES,   SRC_A,   SRC_X,  DST_XP,  '0);
            5'd2:  w = uw(OP_MUL,    SRC_A,   SRC_P,  DST_T,   '0);
            5'd3:  w = uw(OP_MRES,   SRC_A,   SRC_P,  DST_T,   '0);
            5'd4:  w = uw(OP_MUL,    SRC_T,   SRC_A,  DST_T,   '0);
            5'd5:  w = uw(OP_MRES,   SRC_T,   SRC_A,  DST_T,   '0);
            5'd6:  w = uw(OP_ADD,    SRC_T,   SRC_Q,  DST_PP,  '0);
            5'd7:  w = uw(OP_MUL,    SRC_H,   SRC_PP, DST_T,   '0);
            5'd8:  w = uw(OP_MRES,   SRC_H,   SRC_PP, DST_T,   '0);
            5'd9:  w = uw(OP_MUL,    SRC_T,   SRC_H,  DST_T,   '0);
            5'd10: w = uw(OP_MRES,   SRC_T,   SRC_H,  DST_T,   '0);
            5'd11: w = uw(OP_ADD,    SRC_T,   SRC_R,  DST_DEN, '0);
            5'd12: w = uw(OP_MUL,    SRC_PP,  SRC_H,  DST_T,   '0);
            5'd13: w = uw(OP_MRES,   SRC_PP,  SRC_H,  DST_T,   '0);
            5'd14: w = uw(OP_BRNP,   SRC_DEN, SRC_DEN, DST_K,  STEP_NO_GAIN);
            5'd15: w = uw(OP_DSTART, SRC_T,   SRC_DEN, DST_K,  '0);
            5'd16: w = uw(OP_DWAIT,  SRC_T,   SRC_DEN, DST_K,  '0);
            5'd17: w = uw(OP_JMP,    SRC_T,   SRC_T,  DST_K,   STEP_RESID);
            5'd18: w = uw(OP_CLRK,   SRC_T,   SRC_T,  DST_K,   '0);
            5'd19: w = uw(OP_MUL,    SRC_H,   SRC_XP, DST_T,   '0);
            5'd20: w = uw(OP_MRES,   SRC_H,   SRC_XP, DST_T,   '0);
            5'd21: w = uw(OP_SUB,    SRC_Z,   SRC_T,  DST_RES, '0);
            5'd22: w = uw(OP_MUL,    SRC_K,   SRC_RES, DST_T,  '0);
            5'd23: w = uw(OP_MRES,   SRC_K,   SRC_RES, DST_T,  '0);
            5'd24: w = uw(OP_ADD,    SRC_XP,  SRC_T,  DST_X,   '0);
            5'd25: w = uw(OP_MUL,    SRC_K,   SRC_H,  DST_T,   '0);
            5'd26: w = uw(OP_MRES,   SRC_K,   SRC_H,  DST_T,   '0);
            5'd27: w = uw(OP_SUB,    SRC_ONE, SRC_T,  DST_T,   '0);
            5'd28: w = uw(OP_MUL,    SRC_T,   SRC_PP, DST_T,   '0);
            5'd29: w = uw(OP_MRESC,  SRC_T,   SRC_PP, DST_P,   '0);
            default: w = uw(OP_DONE, SRC_T,   SRC_T,  DST_T,   '0);
        endcase
        return w;
    endfunction

    // Product scaled down by the fraction bits (floor), saturated to 32 bits.
    function automatic logic signed [DATA_W-1:0] fx_scale(
            input logic signed [2*DATA_W-1:0] prod);
        logic [2*DATA_W-1-FRAC_BITS:0] sh;
        logic [DATA_W-FRAC_BITS:0]     top;
        logic signed [DATA_W-1:0]      res;
        sh  = prod[2*DATA_W-1:FRAC_BITS];
        top = sh[2*DATA_W-1-FRAC_BITS:DATA_W-1];
        if ((&top) || !(|top)) begin
            res = sh[DATA_W-1:0];
        end else if (top[DATA_W-FRAC_BITS]) begin
            res = S_MIN;
        end else begin
            res = S_MAX;
        end
        return res;
    endfunction

    // Sum or difference saturated to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat_add(
            input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b,
            input logic sub);
        logic signed [DATA_W:0] s;
        logic signed [DATA_W-1:0] res;
        if (sub) begin
            s = (DATA_W+1)'(a) - (DATA_W+1)'(b);
        end else begin
            s = (DATA_W+1)'(a) + (DATA_W+1)'(b);
        end
        if (s[DATA_W] != s[DATA_W-1]) begin
            res = s[DATA_W] ? S_MIN : S_MAX;
        end else begin
            res = s[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/scalar_kalman_filter.sv
// Scalar Kalman filter top level: microcoded sequencer over one multiplier and a serial divider.
//
// Each input word carries one Q16.16 measurement (tdata) and a first-item flag (tuser) that
// reloads the initial estimate and variance before the step. The block works on one word at a
// time: s_axis_tready is low during reset and from acceptance until the result is moved into
// the output register, which then holds it for the sink while the next word may already be
// accepted. The result reaches the output register after the control program steps, which
// share a single 32x32 multiplier, and the 32 iterations of the bit-serial restoring divider
// that forms the gain. When the gain denominator is not positive the divide is skipped.
// A stalled output register keeps the input closed until the result can be handed over.
// Configuration writes are ready whenever the block is out of reset and should only be
// issued while idle.
module scalar_kalman_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [skf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [31:0] measurement
    input  logic                               s_axis_tuser,  // [0] first_item
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [skf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [31:0] estimate,
                                                              // [62:32] variance, [63] zero
    output logic                               m_axis_tuser,  // [0] gain_error
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]         i_cfg_data
);
    import skf_pkg::*;

    // Configuration.
    logic signed [DATA_W-1:0] r_a, r_h, r_x0;
    logic [VAR_W-1:0]         r_q, r_r, r_p0;

    // Datapath registers.
    logic signed [DATA_W-1:0] r_x, r_p, r_z, r_xp, r_pp, r_t, r_k, r_res, r_den;
    logic signed [2*DATA_W-1:0] r_prod;
    logic                     r_err;

    // Sequencer.
    logic                     r_busy;
    logic [PC_W-1:0]          r_pc, n_pc;
    t_uword                   w_uw;

    // Divider.
    logic [DATA_W-1:0]        r_div_rem, r_div_sr, r_div_quo;
    logic [DIV_CNT_W-1:0]     r_div_cnt;
    logic                     r_div_neg, r_div_ovf;

    // Output register.
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_est;
    logic [VAR_W-1:0]         r_out_var;
    logic                     r_out_err;

    logic signed [DATA_W-1:0] w_sa, w_sb, w_wval, w_scaled, w_divq;
    logic signed [2*DATA_W-1:0] w_prod;
    logic                     w_wen, w_out_free, w_in_acc, w_den_np;
    logic [DATA_W-1:0]        w_trial, w_mag;
    logic                     w_ge;
    logic [DATA_W:0]          w_negq;

    function automatic logic signed [DATA_W-1:0] src_sel(input logic [3:0] s,
            input logic signed [DATA_W-1:0] a, h, x, p, z, xp, pp, t, k, res, den,
            input logic [VAR_W-1:0] q, r);
        logic signed [DATA_W-1:0] v;
        case (s)
            SRC_A:   v = a;
            SRC_H:   v = h;
            SRC_Q:   v = {1'b0, q};
            SRC_R:   v = {1'b0, r};
            SRC_X:   v = x;
            SRC_P:   v = p;
            SRC_Z:   v = z;
            SRC_ONE: v = FX_ONE;
            SRC_XP:  v = xp;
            SRC_PP:  v = pp;
            SRC_T:   v = t;
            SRC_K:   v = k;
            SRC_RES: v = res;
            SRC_DEN: v = den;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign o_cfg_ready   = i_rst_n;
    assign s_axis_tready = !r_busy && i_rst_n;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_var, r_out_est};
    assign m_axis_tuser  = r_out_err;

    assign w_uw = skf_urom(r_pc);
    assign w_sa = src_sel(w_uw.src_a, r_a, r_h, r_x, r_p, r_z, r_xp, r_pp, r_t, r_k,
                          r_res, r_den, r_q, r_r);
    assign w_sb = src_sel(w_uw.src_b, r_a, r_h, r_x, r_p, r_z, r_xp, r_pp, r_t, r_k,
                          r_res, r_den, r_q, r_r);
    assign w_prod   = (2*DATA_W)'(w_sa) * (2*DATA_W)'(w_sb);
    assign w_scaled = fx_scale(r_prod);
    assign w_den_np = r_den[DATA_W-1] || (r_den == '0);

    // One restoring step: the remainder stays below the positive denominator.
    assign w_trial = {r_div_rem[DATA_W-2:0], r_div_sr[DATA_W-1]};
    assign w_ge    = w_trial >= DATA_W'(r_den);
    assign w_negq  = '0 - {1'b0, r_div_quo};
    assign w_mag   = r_t[DATA_W-1] ? DATA_W'(0) - DATA_W'(r_t) : DATA_W'(r_t);

    always_comb begin
        if (r_div_ovf) begin
            w_divq = r_div_neg ? S_MIN : S_MAX;
        end else if (r_div_neg) begin
            w_divq = (r_div_quo > DATA_W'(S_MIN)) ? S_MIN : w_negq[DATA_W-1:0];
        end else begin
            w_divq = r_div_quo[DATA_W-1] ? S_MAX : r_div_quo;
        end
    end

    always_comb begin
        w_wen  = 1'b0;
        w_wval = w_scaled;
        n_pc   = r_pc + 1'b1;
        case (w_uw.op)
            OP_MUL: begin
            end
            OP_MRES: begin
                w_wen = 1'b1;
            end
            OP_MRESC: begin
                w_wen  = 1'b1;
                w_wval = w_scaled[DATA_W-1] ? '0 : w_scaled;
            end
            OP_ADD: begin
                w_wen  = 1'b1;
                w_wval = sat_add(w_sa, w_sb, 1'b0);
            end
            OP_SUB: begin
                w_wen  = 1'b1;
                w_wval = sat_add(w_sa, w_sb, 1'b1);
            end
            OP_BRNP: begin
                if (w_den_np) begin
                    n_pc = w_uw.target;
                end
            end
            OP_DSTART: begin
            end
            OP_DWAIT: begin
                if (r_div_cnt != '0) begin
                    n_pc = r_pc;
                end else begin
                    w_wen  = 1'b1;
                    w_wval = w_divq;
                end
            end
            OP_JMP: begin
                n_pc = w_uw.target;
            end
            OP_CLRK: begin
                w_wen  = 1'b1;
                w_wval = '0;
            end
            OP_DONE: begin
                n_pc = w_out_free ? '0 : r_pc;
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
            r_div_cnt   <= '0;
            r_a  <= FX_ONE;
            r_h  <= FX_ONE;
            r_x0 <= FX_ONE;
            r_q  <= VAR_W'(6554);
            r_r  <= VAR_W'(6554);
            r_p0 <= VAR_W'(6554);
            r_x  <= '0;
            r_p  <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TRANS_GAIN: r_a  <= i_cfg_data;
                    CFG_PROC_NOISE: r_q  <= i_cfg_data[VAR_W-1:0];
                    CFG_MEAS_GAIN:  r_h  <= i_cfg_data;
                    CFG_MEAS_NOISE: r_r  <= i_cfg_data[VAR_W-1:0];
                    CFG_INIT_EST:   r_x0 <= i_cfg_data;
                    CFG_INIT_VAR:   r_p0 <= i_cfg_data[VAR_W-1:0];
                    default: begin
                    end
                endcase
            end

            // A finished word refills the output register as the old one leaves.
            if (r_busy && w_uw.op == OP_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_in_acc) begin
                r_busy <= 1'b1;
                r_pc   <= '0;
                if (s_axis_tuser) begin
                    r_x <= r_x0;
                    r_p <= {1'b0, r_p0};
                end
            end else if (r_busy) begin
                r_pc <= n_pc;
                if (w_uw.op == OP_DONE && w_out_free) begin
                    r_busy <= 1'b0;
                end
                if (w_wen && w_uw.dst == DST_X) begin
                    r_x <= w_wval;
                end
                if (w_wen && w_uw.dst == DST_P) begin
                    r_p <= w_wval;
                end
                if (w_uw.op == OP_DSTART) begin
                    r_div_cnt <= DIV_CNT_W'(DIV_STEPS);
                end else if (w_uw.op == OP_DWAIT && r_div_cnt != '0) begin
                    r_div_cnt <= r_div_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath payload.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_z   <= s_axis_tdata;
            r_err <= 1'b0;
        end else if (r_busy) begin
            if (w_uw.op == OP_MUL) begin
                r_prod <= w_prod;
            end
            if (w_uw.op == OP_CLRK) begin
                r_err <= 1'b1;
            end
            if (w_wen) begin
                case (w_uw.dst)
                    DST_XP:  r_xp  <= w_wval;
                    DST_PP:  r_pp  <= w_wval;
                    DST_T:   r_t   <= w_wval;
                    DST_K:   r_k   <= w_wval;
                    DST_RES: r_res <= w_wval;
                    DST_DEN: r_den <= w_wval;
                    default: begin
                    end
                endcase
            end
            if (w_uw.op == OP_DSTART) begin
                // High part of |num| << FRAC_BITS seeds the remainder; an initial
                // remainder not below the divisor means the quotient needs 33+ bits.
                r_div_rem <= DATA_W'(w_mag >> (DATA_W - FRAC_BITS));
                r_div_sr  <= w_mag << FRAC_BITS;
                r_div_quo <= '0;
                r_div_neg <= r_t[DATA_W-1];
                r_div_ovf <= DATA_W'(w_mag >> (DATA_W - FRAC_BITS)) >= DATA_W'(r_den);
            end else if (w_uw.op == OP_DWAIT && r_div_cnt != '0) begin
                r_div_rem <= w_ge ? w_trial - DATA_W'(r_den) : w_trial;
                r_div_sr  <= {r_div_sr[DATA_W-2:0], 1'b0};
                r_div_quo <= {r_div_quo[DATA_W-2:0], w_ge};
            end
            if (w_uw.op == OP_DONE && w_out_free) begin
                r_out_est <= r_x;
                r_out_var <= r_p[VAR_W-1:0];
                r_out_err <= r_err;
            end
        end
    end

endmodule

### hw/rtl/skf_checker.sv
// Port-level checker for the scalar Kalman filter and its bind to the top level.
module skf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [skf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [skf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [skf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [skf_pkg::DATA_W-1:0]      i_cfg_data
);
    // An accepted word keeps the input closed while the filter runs.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still ready right after a word was accepted");

    // The input reopens only when a result has been placed on the output.
    a_result_on_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(s_axis_tready) && $past(i_rst_n) |-> m_axis_tvalid)
        else $error("input reopened without a result on the output");

    // The variance never goes negative and the pad bit is tied to zero, so it stays clear.
    a_pad_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[63])
        else $error("output pad bit set");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (.*);
